// File: design/gpbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gpbw_pkg;

  // Field widths
  localparam int COORD_BITS    = 14;
  localparam int COLOR_BITS    = 16;
  localparam int OFFSET_BITS   = 8;
  localparam int DIM_BITS      = 13;
  localparam int BYTES_BITS    = 26;
  localparam int ADDR_BITS     = 24;
  localparam int INDEX_BITS    = 2 * DIM_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 26;

  // Register reset values
  localparam logic [DIM_BITS-1:0]   RST_SCREEN_WIDTH  = DIM_BITS'(240);
  localparam logic [DIM_BITS-1:0]   RST_SCREEN_HEIGHT = DIM_BITS'(320);
  localparam logic [BYTES_BITS-1:0] RST_SCREEN_BYTES  = BYTES_BITS'(153600);
  localparam logic [COLOR_BITS-1:0] RST_KEY_COLOR     = '1;
  localparam logic [COLOR_BITS-1:0] RST_RECOLOR_VALUE = '0;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_SCREEN_BYTES   = 3'd2,
    REG_KEY_ENABLE     = 3'd3,
    REG_KEY_COLOR      = 3'd4,
    REG_INVERT_ENABLE  = 3'd5,
    REG_RECOLOR_ENABLE = 3'd6,
    REG_RECOLOR_VALUE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   screen_width;
    logic [DIM_BITS-1:0]   screen_height;
    logic [BYTES_BITS-1:0] screen_bytes;
    logic                  key_enable;
    logic [COLOR_BITS-1:0] key_color;
    logic                  invert_enable;
    logic                  recolor_enable;
    logic [COLOR_BITS-1:0] recolor_value;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/gpbw_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gpbw_pixel_if #(
  parameter int COORD_BITS = gpbw_pkg::COORD_BITS
);
  logic                                    valid;
  logic                                    ready;
  logic signed [COORD_BITS-1:0]            origin_x;
  logic signed [COORD_BITS-1:0]            origin_y;
  logic [gpbw_pkg::OFFSET_BITS-1:0]        glyph_row;
  logic [gpbw_pkg::OFFSET_BITS-1:0]        glyph_col;
  logic [gpbw_pkg::COLOR_BITS-1:0]         pixel_color;

  modport source (
    output valid, origin_x, origin_y, glyph_row, glyph_col, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, glyph_row, glyph_col, pixel_color,
    output ready
  );
endinterface
`default_nettype wire

// File: design/gpbw_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gpbw_result_if;
  logic                            valid;
  logic                            ready;
  logic                            write_enable;
  logic [gpbw_pkg::ADDR_BITS-1:0]  pixel_address;
  logic [gpbw_pkg::COLOR_BITS-1:0] out_color;
  logic                            halt;

  modport source (
    output valid, write_enable, pixel_address, out_color, halt,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, out_color, halt,
    output ready
  );
endinterface
`default_nettype wire

// File: design/gpbw_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gpbw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gpbw_pkg::CFG_IDX_BITS-1:0]  index;
  logic [gpbw_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/gpbw_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module gpbw_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  gpbw_cfg_if.sink            cfg,
  output gpbw_pkg::cfg_t      regs
);

  // Always take a write beat
  assign cfg.ready = 1'b1;

  // Decode index and update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.screen_width   <= gpbw_pkg::RST_SCREEN_WIDTH;
      regs.screen_height  <= gpbw_pkg::RST_SCREEN_HEIGHT;
      regs.screen_bytes   <= gpbw_pkg::RST_SCREEN_BYTES;
      regs.key_enable     <= 1'b0;
      regs.key_color      <= gpbw_pkg::RST_KEY_COLOR;
      regs.invert_enable  <= 1'b0;
      regs.recolor_enable <= 1'b0;
      regs.recolor_value  <= gpbw_pkg::RST_RECOLOR_VALUE;
    end else if (cfg.valid) begin
      unique case (gpbw_pkg::cfg_reg_t'(cfg.index))
        gpbw_pkg::REG_SCREEN_WIDTH:
          regs.screen_width <= cfg.data[gpbw_pkg::DIM_BITS-1:0];
        gpbw_pkg::REG_SCREEN_HEIGHT:
          regs.screen_height <= cfg.data[gpbw_pkg::DIM_BITS-1:0];
        gpbw_pkg::REG_SCREEN_BYTES:
          regs.screen_bytes <= cfg.data[gpbw_pkg::BYTES_BITS-1:0];
        gpbw_pkg::REG_KEY_ENABLE:     regs.key_enable     <= cfg.data[0];
        gpbw_pkg::REG_KEY_COLOR:
          regs.key_color <= cfg.data[gpbw_pkg::COLOR_BITS-1:0];
        gpbw_pkg::REG_INVERT_ENABLE:  regs.invert_enable  <= cfg.data[0];
        gpbw_pkg::REG_RECOLOR_ENABLE: regs.recolor_enable <= cfg.data[0];
        gpbw_pkg::REG_RECOLOR_VALUE:
          regs.recolor_value <= cfg.data[gpbw_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/gpbw_wrap_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module gpbw_wrap_lane #(
  parameter int COORD_BITS = gpbw_pkg::COORD_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                adv,
  input  wire logic signed [COORD_BITS-1:0]        origin,
  input  wire logic [gpbw_pkg::OFFSET_BITS-1:0]    offset,
  input  wire logic [gpbw_pkg::DIM_BITS-1:0]       modulus,
  output logic      [gpbw_pkg::DIM_BITS-1:0]       wrapped
);

  localparam int SUM_BITS = COORD_BITS + 2;
  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int DIM_BITS = gpbw_pkg::DIM_BITS;

  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] sum_neg;

  // One stage per dividend bit; index 0 is the capture stage
  logic [DIM_BITS-1:0] rem [MAG_BITS+1];
  logic [MAG_BITS-1:0] dvd [MAG_BITS+1];
  logic                neg [MAG_BITS+1];

  // Screen position and its magnitude
  assign sum = $signed({{2{origin[COORD_BITS-1]}}, origin})
             + $signed({{(SUM_BITS-gpbw_pkg::OFFSET_BITS){1'b0}}, offset});
  assign sum_neg = -sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      neg[0] <= sum[SUM_BITS-1];
      dvd[0] <= sum[SUM_BITS-1] ? sum_neg[MAG_BITS-1:0] : sum[MAG_BITS-1:0];
      rem[0] <= '0;
    end
  end

  // Restoring remainder, one bit per stage
  for (genvar k = 0; k < MAG_BITS; k++) begin : g_div
    logic [DIM_BITS:0] trial;
    logic [DIM_BITS:0] trial_sub;

    assign trial     = {rem[k], dvd[k][MAG_BITS-1]};
    assign trial_sub = trial - {1'b0, modulus};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= (trial >= {1'b0, modulus}) ? trial_sub[DIM_BITS-1:0]
                                               : trial[DIM_BITS-1:0];
        dvd[k+1] <= {dvd[k][MAG_BITS-2:0], 1'b0};
        neg[k+1] <= neg[k];
      end
    end
  end

  // Fold negative positions back into range; zero modulus gives zero
  always_ff @(posedge clk) begin
    if (adv) begin
      if (modulus == '0) begin
        wrapped <= '0;
      end else if (neg[MAG_BITS] && rem[MAG_BITS] != '0) begin
        wrapped <= modulus - rem[MAG_BITS];
      end else begin
        wrapped <= rem[MAG_BITS];
      end
    end
  end

endmodule
`default_nettype wire

// File: design/gpbw_addr_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module gpbw_addr_unit (
  input  wire logic                               clk,
  input  wire logic                               adv,
  input  wire gpbw_pkg::cfg_t                     regs,
  input  wire logic [gpbw_pkg::DIM_BITS-1:0]      wx,
  input  wire logic [gpbw_pkg::DIM_BITS-1:0]      wy,
  input  wire logic [gpbw_pkg::COLOR_BITS-1:0]    color,
  output logic                                    write_enable,
  output logic [gpbw_pkg::ADDR_BITS-1:0]          pixel_address,
  output logic [gpbw_pkg::COLOR_BITS-1:0]         out_color,
  output logic                                    halt
);

  localparam int IDX_BITS  = gpbw_pkg::INDEX_BITS + 1;
  localparam int BYTE_BITS = IDX_BITS + 1;

  logic [gpbw_pkg::INDEX_BITS-1:0] prod;
  logic [gpbw_pkg::DIM_BITS-1:0]   mx;
  logic [gpbw_pkg::COLOR_BITS-1:0] color_a;

  logic [IDX_BITS-1:0]             index;
  logic [BYTE_BITS-1:0]            byte_end;
  logic                            over;
  logic                            skip;
  logic [gpbw_pkg::COLOR_BITS-1:0] color_inv;
  logic [gpbw_pkg::COLOR_BITS-1:0] color_fin;

  // Row base product
  always_ff @(posedge clk) begin
    if (adv) begin
      prod    <= wy * regs.screen_width;
      mx      <= wx;
      color_a <= color;
    end
  end

  // Pixel index and bound check on the byte address just past the pixel's last byte
  assign index    = {1'b0, prod} + {{(IDX_BITS-gpbw_pkg::DIM_BITS){1'b0}}, mx};
  assign byte_end = {index, 1'b0} + BYTE_BITS'(2);
  assign over     = byte_end > {{(BYTE_BITS-gpbw_pkg::BYTES_BITS){1'b0}}, regs.screen_bytes};

  // Key, invert, recolor
  assign skip      = regs.key_enable && (color_a == regs.key_color);
  assign color_inv = regs.invert_enable ? ~color_a : color_a;
  assign color_fin = regs.recolor_enable ? regs.recolor_value : color_inv;

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_address <= index[gpbw_pkg::ADDR_BITS-1:0];
      write_enable  <= !skip && !over;
      halt          <= !skip && over;
      out_color     <= (!skip && !over) ? color_fin : '0;
    end
  end

endmodule
`default_nettype wire

// File: design/glyph_pixel_blit_wrap_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Glyph pixel blitter with screen wrap and color key.
// pixel:  one glyph pixel per beat (glyph origin, row/col inside glyph, color).
// result: one beat per pixel: write_enable, framebuffer pixel_address, out_color
//         and halt when an unkeyed pixel lies past the framebuffer end.
// cfg:    register writes (index, data); always ready. Write only while idle.
// The pipe holds one capture stage, one remainder stage per magnitude bit
// (COORD_BITS + 1) for the x and y wrap, a fold stage, the row multiply and
// the final add/compare/output stage. Throughput is one pixel per cycle
// while result is not stalled; the wrap remainder is computed by a
// pipelined restoring divider, one bit per stage, in each coordinate lane.
// Reset clears all stage valid bits and loads register defaults
// (240 x 320, 153600 bytes, key off, key 0xFFFF, invert and recolor off).
// The whole pipe advances together: when result is stalled with a beat
// waiting, every stage holds and pixel.ready drops; nothing is lost or
// repeated. With the output empty, ready stays high even under back-pressure.
module glyph_pixel_blit_wrap_unit #(
  parameter int COORD_BITS = gpbw_pkg::COORD_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  gpbw_pixel_if.sink    pixel,
  gpbw_result_if.source result,
  gpbw_cfg_if.sink      cfg
);

  localparam int LANE_DEPTH = COORD_BITS + 3;
  localparam int LAT        = LANE_DEPTH + 2;

  gpbw_pkg::cfg_t                  regs;
  logic                            adv;
  logic [LAT-1:0]                  vld;
  logic [gpbw_pkg::COLOR_BITS-1:0] color_dly [LANE_DEPTH];
  logic [gpbw_pkg::DIM_BITS-1:0]   wx;
  logic [gpbw_pkg::DIM_BITS-1:0]   wy;

  gpbw_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Advance the whole pipe unless the output beat is stalled
  assign adv          = !vld[LAT-1] || result.ready;
  assign pixel.ready  = adv;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], pixel.valid};
    end
  end

  // Carry color alongside the wrap lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      color_dly[0] <= pixel.pixel_color;
    end
  end

  for (genvar k = 1; k < LANE_DEPTH; k++) begin : g_color
    always_ff @(posedge clk) begin
      if (adv) begin
        color_dly[k] <= color_dly[k-1];
      end
    end
  end

  gpbw_wrap_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk     (clk),
    .adv     (adv),
    .origin  (pixel.origin_x),
    .offset  (pixel.glyph_col),
    .modulus (regs.screen_width),
    .wrapped (wx)
  );

  gpbw_wrap_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk     (clk),
    .adv     (adv),
    .origin  (pixel.origin_y),
    .offset  (pixel.glyph_row),
    .modulus (regs.screen_height),
    .wrapped (wy)
  );

  gpbw_addr_unit u_addr (
    .clk           (clk),
    .adv           (adv),
    .regs          (regs),
    .wx            (wx),
    .wy            (wy),
    .color         (color_dly[LANE_DEPTH-1]),
    .write_enable  (result.write_enable),
    .pixel_address (result.pixel_address),
    .out_color     (result.out_color),
    .halt          (result.halt)
  );

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gpbw_pkg::*;

  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam longint unsigned BYTES_MAX = (64'd1 << BYTES_BITS) - 1;

  typedef struct {
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic [OFFSET_BITS-1:0]       row;
    logic [OFFSET_BITS-1:0]       col;
    logic [COLOR_BITS-1:0]        color;
  } glyph_pixel_t;

  typedef struct {
    logic                  we;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  halt;
  } fb_write_t;

  logic clk;
  logic rst;

  gpbw_pixel_if  px ();
  gpbw_result_if res ();
  gpbw_cfg_if    cf ();

  glyph_pixel_blit_wrap_unit dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (px),
    .result (res),
    .cfg    (cf)
  );

  glyph_pixel_t pixel_queue[$];
  fb_write_t    write_expect[$];

  cfg_t shadow_cfg = '{
    screen_width:   RST_SCREEN_WIDTH,
    screen_height:  RST_SCREEN_HEIGHT,
    screen_bytes:   RST_SCREEN_BYTES,
    key_enable:     1'b0,
    key_color:      RST_KEY_COLOR,
    invert_enable:  1'b0,
    recolor_enable: 1'b0,
    recolor_value:  RST_RECOLOR_VALUE
  };

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit pix_taken      = 1'b0;
  bit res_taken      = 1'b0;
  int send_gap       = 0;
  int stall_left     = 0;
  bit pix_burst      = 1'b0;
  bit res_burst      = 1'b0;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
  end

  // Positive remainder of v by m; a zero modulus folds to 0
  function automatic longint unsigned wrap_coord(int v, logic [DIM_BITS-1:0] m);
    int mi;
    int r;
    if (m == 0) return 0;
    mi = int'(m);
    r = v % mi;
    if (r < 0) r += mi;
    return r;
  endfunction

  // Framebuffer write caused by one glyph pixel under the given setup
  function automatic fb_write_t predict_fb_write(glyph_pixel_t p, cfg_t c);
    int sx;
    int sy;
    longint unsigned wx;
    longint unsigned wy;
    longint unsigned pix_index;
    longint unsigned byte_limit;
    logic [COLOR_BITS-1:0] shade;
    fb_write_t w;
    sx = p.ox;
    sx = sx + int'(p.col);
    sy = p.oy;
    sy = sy + int'(p.row);
    wx = wrap_coord(sx, c.screen_width);
    wy = wrap_coord(sy, c.screen_height);
    pix_index = wy * c.screen_width + wx;
    w.we = 1'b0;
    w.halt = 1'b0;
    w.color = '0;
    w.addr = pix_index[ADDR_BITS-1:0];
    // Transparent pixels are dropped before the bound check
    if (!(c.key_enable && p.color == c.key_color)) begin
      shade = c.invert_enable ? ~p.color : p.color;
      byte_limit = c.screen_bytes;
      if (byte_limit < 2 || pix_index * 2 > byte_limit - 2) begin
        w.halt = 1'b1;
      end else begin
        w.we = 1'b1;
        w.color = c.recolor_enable ? c.recolor_value : shade;
      end
    end
    return w;
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Pixel driver: present queued pixels with a random gap after each
  always @(negedge clk) begin
    if (rst) begin
      px.valid <= 1'b0;
    end else if (!px.valid || pix_taken) begin
      if (send_gap != 0) begin
        px.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        px.origin_x    <= pixel_queue[0].ox;
        px.origin_y    <= pixel_queue[0].oy;
        px.glyph_row   <= pixel_queue[0].row;
        px.glyph_col   <= pixel_queue[0].col;
        px.pixel_color <= pixel_queue[0].color;
        px.valid       <= 1'b1;
        void'(pixel_queue.pop_front());
        if ($urandom_range(0, 40) == 0) pix_burst = !pix_burst;
        send_gap = draw_wait(pix_burst);
      end else begin
        px.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall a random number of cycles after each beat
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        if ($urandom_range(0, 40) == 0) res_burst = !res_burst;
        stall_left = draw_wait(res_burst);
      end
      if (stall_left != 0) begin
        res.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each pixel beat, compare on each result beat
  always @(posedge clk) begin : monitor
    glyph_pixel_t got_pixel;
    fb_write_t    want;
    pix_taken <= !rst && px.valid && px.ready;
    res_taken <= !rst && res.valid && res.ready;
    if (!rst) begin
      if (px.valid && px.ready) begin
        got_pixel.ox    = px.origin_x;
        got_pixel.oy    = px.origin_y;
        got_pixel.row   = px.glyph_row;
        got_pixel.col   = px.glyph_col;
        got_pixel.color = px.pixel_color;
        write_expect.push_back(predict_fb_write(got_pixel, shadow_cfg));
      end
      if (res.valid && res.ready) begin
        if (write_expect.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing expected: %s%0b %s%06h %s%04h %s%0b",
                     $realtime, "we=", res.write_enable, "addr=", res.pixel_address,
                     "color=", res.out_color, "halt=", res.halt);
        end else begin
          want = write_expect.pop_front();
          if (res.write_enable !== want.we || res.pixel_address !== want.addr ||
              res.out_color !== want.color || res.halt !== want.halt) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp we=%0b addr=%06h color=%04h halt=%0b,",
                       $realtime, want.we, want.addr, want.color, want.halt);
              $display("    got we=%0b addr=%06h color=%04h halt=%0b",
                       res.write_enable, res.pixel_address, res.out_color, res.halt);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (px.valid && px.ready) || (res.valid && res.ready) || (cf.valid && cf.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_pixel(input logic [COORD_BITS-1:0] ox, input logic [COORD_BITS-1:0] oy,
                            input logic [OFFSET_BITS-1:0] row,
                            input logic [OFFSET_BITS-1:0] col,
                            input logic [COLOR_BITS-1:0] color);
    glyph_pixel_t p;
    p.ox = ox;
    p.oy = oy;
    p.row = row;
    p.col = col;
    p.color = color;
    pixel_queue.push_back(p);
  endtask

  // Wait until every queued pixel has been sent and every write has come back
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_queue.size() != 0 || px.valid || write_expect.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cf.valid <= 1'b1;
    cf.index <= idx;
    cf.data  <= val;
    do @(posedge clk); while (!(cf.valid && cf.ready));
    case (idx)
      REG_SCREEN_WIDTH:   shadow_cfg.screen_width   = val[DIM_BITS-1:0];
      REG_SCREEN_HEIGHT:  shadow_cfg.screen_height  = val[DIM_BITS-1:0];
      REG_SCREEN_BYTES:   shadow_cfg.screen_bytes   = val[BYTES_BITS-1:0];
      REG_KEY_ENABLE:     shadow_cfg.key_enable     = val[0];
      REG_KEY_COLOR:      shadow_cfg.key_color      = val[COLOR_BITS-1:0];
      REG_INVERT_ENABLE:  shadow_cfg.invert_enable  = val[0];
      REG_RECOLOR_ENABLE: shadow_cfg.recolor_enable = val[0];
      REG_RECOLOR_VALUE:  shadow_cfg.recolor_value  = val[COLOR_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cf.valid <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_SCREEN_WIDTH,   CFG_DATA_BITS'(c.screen_width));
    write_reg(REG_SCREEN_HEIGHT,  CFG_DATA_BITS'(c.screen_height));
    write_reg(REG_SCREEN_BYTES,   CFG_DATA_BITS'(c.screen_bytes));
    write_reg(REG_KEY_ENABLE,     CFG_DATA_BITS'(c.key_enable));
    write_reg(REG_KEY_COLOR,      CFG_DATA_BITS'(c.key_color));
    write_reg(REG_INVERT_ENABLE,  CFG_DATA_BITS'(c.invert_enable));
    write_reg(REG_RECOLOR_ENABLE, CFG_DATA_BITS'(c.recolor_enable));
    write_reg(REG_RECOLOR_VALUE,  CFG_DATA_BITS'(c.recolor_value));
  endtask

  // Screen dimension: mostly small so wrapping is frequent, with extremes
  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return DIM_BITS'(1);
      1:       return DIM_BITS'(4096);
      2:       return DIM_BITS'($urandom_range(0, 8191));
      3:       return DIM_BITS'($urandom_range(1, 4096));
      default: return DIM_BITS'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    longint unsigned full;
    c.screen_width  = pick_dim();
    c.screen_height = pick_dim();
    full = 2 * longint'(c.screen_width) * c.screen_height;
    if (full > BYTES_MAX) full = BYTES_MAX;
    case ($urandom_range(0, 6))
      0:       c.screen_bytes = BYTES_BITS'(full);
      1:       c.screen_bytes = BYTES_BITS'($urandom_range(0, 3));
      2:       c.screen_bytes = BYTES_BITS'(BYTES_MAX);
      3:       c.screen_bytes = BYTES_BITS'(33554432);
      default: c.screen_bytes = BYTES_BITS'($urandom_range(0, 32'(full) + 2));
    endcase
    c.key_enable     = 1'($urandom_range(0, 1));
    c.key_color      = ($urandom_range(0, 3) == 0) ? '1 : COLOR_BITS'($urandom);
    c.invert_enable  = 1'($urandom_range(0, 1));
    c.recolor_enable = 1'($urandom_range(0, 1));
    c.recolor_value  = COLOR_BITS'($urandom);
    return c;
  endfunction

  // Glyph origin: near the screen edges, just off screen, or anywhere
  function automatic logic [COORD_BITS-1:0] pick_origin(int m);
    int v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = -int'($urandom_range(0, 16));
      2:       v = m - int'($urandom_range(0, 8));
      default: v = int'($urandom_range(0, m));
    endcase
    return v[COORD_BITS-1:0];
  endfunction

  initial begin : stimulus
    int queued;
    int gw;
    int gh;
    int rb;
    int cb;
    logic [COORD_BITS-1:0] gx;
    logic [COORD_BITS-1:0] gy;
    logic [COLOR_BITS-1:0] fg;
    logic [COLOR_BITS-1:0] bg;

    px.valid = 1'b0;
    px.origin_x = '0;
    px.origin_y = '0;
    px.glyph_row = '0;
    px.glyph_col = '0;
    px.pixel_color = '0;
    res.ready = 1'b0;
    cf.valid = 1'b0;
    cf.index = REG_SCREEN_WIDTH;
    cf.data = '0;

    @(negedge clk);
    while (rst) @(negedge clk);

    // Reset setup: field extremes, negative wrap, last pixel exactly in bounds
    push_pixel(0, 0, 0, 0, 16'h0000);
    push_pixel(0, 0, 255, 255, 16'hFFFF);
    push_pixel(-8192, -8192, 0, 0, 16'h8001);
    push_pixel(8191, 8191, 255, 255, 16'h7FFE);
    push_pixel(-1, -1, 0, 0, 16'h5555);
    push_pixel(239, 319, 0, 0, 16'hAAAA);
    push_pixel(-8192, 8191, 255, 0, 16'hFFFF);
    push_pixel(8191, -8192, 0, 255, 16'h0001);
    drain();

    // Last pixel one past the end, key on, invert on
    apply_config(cfg_t'{screen_width: 240, screen_height: 320, screen_bytes: 153598,
                        key_enable: 1, key_color: 16'h1234, invert_enable: 1,
                        recolor_enable: 0, recolor_value: 16'hFFFF});
    push_pixel(-1, -1, 0, 0, 16'h1111);
    push_pixel(238, 319, 0, 0, 16'h1111);
    push_pixel(5, 5, 3, 3, 16'h1234);
    push_pixel(-1, -1, 0, 0, 16'h1234);
    push_pixel(0, 0, 0, 0, 16'hEDCB);
    drain();

    // Zero resolution with a tiny framebuffer, recolor on
    apply_config(cfg_t'{screen_width: 0, screen_height: 0, screen_bytes: 1,
                        key_enable: 0, key_color: 16'h0000, invert_enable: 0,
                        recolor_enable: 1, recolor_value: 16'hBEEF});
    push_pixel(100, -100, 7, 9, 16'h0F0F);
    push_pixel(0, 0, 0, 0, 16'h0000);
    drain();

    // Largest screen: addresses wider than the output field
    apply_config(cfg_t'{screen_width: 8191, screen_height: 8191,
                        screen_bytes: BYTES_BITS'(BYTES_MAX),
                        key_enable: 1, key_color: 16'h0000, invert_enable: 1,
                        recolor_enable: 1, recolor_value: 16'hBEEF});
    push_pixel(-1, -1, 0, 0, 16'h0000);
    push_pixel(-1, -1, 0, 0, 16'h0001);
    push_pixel(100, 2000, 0, 0, 16'hFFFF);
    push_pixel(0, 3000, 0, 0, 16'h1357);
    push_pixel(8191, 4000, 255, 255, 16'h2468);
    drain();

    // Single-pixel screen
    apply_config(cfg_t'{screen_width: 1, screen_height: 1, screen_bytes: 2,
                        key_enable: 0, key_color: 16'hFFFF, invert_enable: 0,
                        recolor_enable: 0, recolor_value: 16'h0000});
    push_pixel(-8192, -8192, 255, 255, 16'h2468);
    push_pixel(8191, 8191, 255, 255, 16'hFFFF);
    drain();

    // Random phases: mostly whole glyphs in raster order, some stray pixels
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config(random_setup());
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          push_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom), OFFSET_BITS'($urandom),
                     OFFSET_BITS'($urandom), COLOR_BITS'($urandom));
          queued++;
        end else begin
          gx = pick_origin(shadow_cfg.screen_width);
          gy = pick_origin(shadow_cfg.screen_height);
          gw = $urandom_range(1, 8);
          gh = $urandom_range(1, 8);
          rb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 256 - gh) : 0;
          cb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 256 - gw) : 0;
          fg = COLOR_BITS'($urandom);
          bg = ($urandom_range(0, 3) != 0) ? shadow_cfg.key_color : 16'($urandom);
          for (int r = 0; r < gh; r++)
            for (int c = 0; c < gw; c++)
              push_pixel(gx, gy, OFFSET_BITS'(rb + r), OFFSET_BITS'(cb + c),
                         $urandom_range(0, 1) ? fg : bg);
          queued += gw * gh;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/gpbw_pkg.sv
design/gpbw_pixel_if.sv
design/gpbw_result_if.sv
design/gpbw_cfg_if.sv
design/gpbw_cfg_regs.sv
design/gpbw_wrap_lane.sv
design/gpbw_addr_unit.sv
design/glyph_pixel_blit_wrap_unit.sv
sim/tb_top.sv
